### rtl/perlin_gradient_noise_turbulence_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gradient noise block
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PERLIN_GRADIENT_NOISE_TURBULENCE_MACROS_SVH
`define PERLIN_GRADIENT_NOISE_TURBULENCE_MACROS_SVH

`ifndef SYNTH
`define PGN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pgn assertion failed");
`define PGN_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("pgn forbidden condition");
`else
`define PGN_ASSERT(lbl, prop)
`define PGN_NEVER(lbl, expr)
`endif

`endif

### rtl/pgn_pkg.sv
// ----------------------------------------------------------------------------
// pgn_pkg
// Shared widths, operation codes and controller commands.
// ----------------------------------------------------------------------------
`default_nettype none
package pgn_pkg;

  localparam int TBL_AW = 8;
  localparam int FRAC   = 16;
  localparam int MAXOCT = 8;

  // item operations
  localparam logic [2:0] OP_LOAD_PX = 3'd0;
  localparam logic [2:0] OP_LOAD_PY = 3'd1;
  localparam logic [2:0] OP_LOAD_PZ = 3'd2;
  localparam logic [2:0] OP_LOAD_G  = 3'd3;
  localparam logic [2:0] OP_NOISE   = 3'd4;
  localparam logic [2:0] OP_TURB    = 3'd5;

  // datapath steps
  localparam logic [3:0] DP_IDLE     = 4'd0;
  localparam logic [3:0] DP_LOAD     = 4'd1;
  localparam logic [3:0] DP_START    = 4'd2;
  localparam logic [3:0] DP_FADE_SQ  = 4'd3;
  localparam logic [3:0] DP_FADE_MUL = 4'd4;
  localparam logic [3:0] DP_PERM_RD  = 4'd5;
  localparam logic [3:0] DP_GRAD_RD  = 4'd6;
  localparam logic [3:0] DP_DOT_X    = 4'd7;
  localparam logic [3:0] DP_DOT_Y    = 4'd8;
  localparam logic [3:0] DP_DOT_Z    = 4'd9;
  localparam logic [3:0] DP_W_X      = 4'd10;
  localparam logic [3:0] DP_W_Y      = 4'd11;
  localparam logic [3:0] DP_W_Z      = 4'd12;
  localparam logic [3:0] DP_OCT_END  = 4'd13;
  localparam logic [3:0] DP_FINISH   = 4'd14;

  // 3 * 2^FRAC used by the fade polynomial
  localparam logic [17:0] FADE_K = 18'd196608;
  localparam logic [16:0] ONE_W  = 17'h10000;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] axis;
    logic [2:0] corner;
    logic [2:0] octave;
  } pgn_cmd_t;

endpackage
`default_nettype wire

### rtl/pgn_ctrl.sv
// ----------------------------------------------------------------------------
// pgn_ctrl
// Sequencer: walks fade, eight corners and octave end for each octave.
// ----------------------------------------------------------------------------
`default_nettype none
module pgn_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [2:0]      in_op,
  input  wire logic [3:0]      in_octaves,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output pgn_pkg::pgn_cmd_t    cmd
);
  import pgn_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FADE_SQ  = 4'd1;
  localparam logic [3:0] S_FADE_MUL = 4'd2;
  localparam logic [3:0] S_PERM     = 4'd3;
  localparam logic [3:0] S_GRAD     = 4'd4;
  localparam logic [3:0] S_DOT_X    = 4'd5;
  localparam logic [3:0] S_DOT_Y    = 4'd6;
  localparam logic [3:0] S_DOT_Z    = 4'd7;
  localparam logic [3:0] S_W_X      = 4'd8;
  localparam logic [3:0] S_W_Y      = 4'd9;
  localparam logic [3:0] S_W_Z      = 4'd10;
  localparam logic [3:0] S_OCT_END  = 4'd11;
  localparam logic [3:0] S_FINISH   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [2:0] corner_r, corner_nxt;
  logic [2:0] oct_r, oct_nxt;
  logic [3:0] noct_r, noct_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       accept;
  logic       is_eval;
  logic [3:0] n_req;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign accept     = in_tvalid && in_tready;
  assign is_eval    = (in_op == OP_NOISE) || (in_op == OP_TURB);
  assign n_req      = (in_op == OP_NOISE) ? 4'd1 :
                      (in_octaves > 4'(MAXOCT)) ? 4'(MAXOCT) : in_octaves;

  always_comb begin
    state_nxt  = state_r;
    axis_nxt   = axis_r;
    corner_nxt = corner_r;
    oct_nxt    = oct_r;
    noct_nxt   = noct_r;
    ovalid_nxt = ovalid_r && !out_tready;
    cmd.op     = DP_IDLE;
    cmd.axis   = axis_r;
    cmd.corner = corner_r;
    cmd.octave = oct_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_eval) begin
            cmd.op    = DP_START;
            noct_nxt  = n_req;
            oct_nxt   = 3'd0;
            axis_nxt  = 2'd0;
            state_nxt = (n_req == 4'd0) ? S_FINISH : S_FADE_SQ;
          end else if (in_op == OP_LOAD_PX || in_op == OP_LOAD_PY ||
                       in_op == OP_LOAD_PZ || in_op == OP_LOAD_G) begin
            cmd.op = DP_LOAD;
          end
        end
      end
      S_FADE_SQ: begin
        cmd.op    = DP_FADE_SQ;
        state_nxt = S_FADE_MUL;
      end
      S_FADE_MUL: begin
        cmd.op = DP_FADE_MUL;
        if (axis_r == 2'd2) begin
          corner_nxt = 3'd0;
          state_nxt  = S_PERM;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_FADE_SQ;
        end
      end
      S_PERM: begin
        cmd.op    = DP_PERM_RD;
        state_nxt = S_GRAD;
      end
      S_GRAD: begin
        cmd.op    = DP_GRAD_RD;
        state_nxt = S_DOT_X;
      end
      S_DOT_X: begin
        cmd.op    = DP_DOT_X;
        state_nxt = S_DOT_Y;
      end
      S_DOT_Y: begin
        cmd.op    = DP_DOT_Y;
        state_nxt = S_DOT_Z;
      end
      S_DOT_Z: begin
        cmd.op    = DP_DOT_Z;
        state_nxt = S_W_X;
      end
      S_W_X: begin
        cmd.op    = DP_W_X;
        state_nxt = S_W_Y;
      end
      S_W_Y: begin
        cmd.op    = DP_W_Y;
        state_nxt = S_W_Z;
      end
      S_W_Z: begin
        cmd.op = DP_W_Z;
        if (corner_r == 3'd7) begin
          state_nxt = S_OCT_END;
        end else begin
          corner_nxt = corner_r + 3'd1;
          state_nxt  = S_PERM;
        end
      end
      S_OCT_END: begin
        cmd.op = DP_OCT_END;
        if ({1'b0, oct_r} + 4'd1 == noct_r) begin
          state_nxt = S_FINISH;
        end else begin
          oct_nxt   = oct_r + 3'd1;
          axis_nxt  = 2'd0;
          state_nxt = S_FADE_SQ;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!ovalid_r || out_tready) begin
          cmd.op     = DP_FINISH;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      axis_r   <= 2'd0;
      corner_r <= 3'd0;
      oct_r    <= 3'd0;
      noct_r   <= 4'd0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      axis_r   <= axis_nxt;
      corner_r <= corner_nxt;
      oct_r    <= oct_nxt;
      noct_r   <= noct_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/pgn_dpath.sv
// ----------------------------------------------------------------------------
// pgn_dpath
// Tables, shared multiplier and accumulators for the noise evaluation.
// ----------------------------------------------------------------------------
`default_nettype none
module pgn_dpath (
  input  wire logic                clk,
  input  wire pgn_pkg::pgn_cmd_t   cmd,
  input  wire logic [2:0]          in_op,
  input  wire logic [7:0]          entry_index,
  input  wire logic [7:0]          perm_value,
  input  wire logic signed [15:0]  grad_x,
  input  wire logic signed [15:0]  grad_y,
  input  wire logic signed [15:0]  grad_z,
  input  wire logic signed [31:0]  point_x,
  input  wire logic signed [31:0]  point_y,
  input  wire logic signed [31:0]  point_z,
  output logic signed [19:0]       noise_value
);
  import pgn_pkg::*;

  logic [7:0]  perm_x_mem [256];
  logic [7:0]  perm_y_mem [256];
  logic [7:0]  perm_z_mem [256];
  logic [47:0] grad_mem   [256];

  logic [23:0]        p_r [3];
  logic [16:0]        fade_r [3];
  logic [15:0]        tmp_r;
  logic [7:0]         pxq_r, pyq_r, pzq_r;
  logic [47:0]        gq_r;
  logic signed [34:0] dot_r;
  logic signed [23:0] d_r;
  logic signed [23:0] acc_r;
  logic signed [33:0] total_r;
  logic               turb_r;
  logic signed [19:0] noise_r;

  logic [15:0]        f_sel;
  logic signed [23:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [43:0] mul_p;
  logic signed [23:0] prod_sh;
  logic signed [19:0] dot_sh;
  logic signed [16:0] ox, oy, oz;
  logic [16:0]        wx, wy, wz;
  logic [7:0]         ax, ay, az, gidx;
  logic signed [33:0] acc_ext, acc_scaled;
  logic signed [33:0] mag;
  logic signed [26:0] res;
  logic signed [19:0] sat;

  assign f_sel   = p_r[cmd.axis][15:0];
  assign ox = $signed({1'b0, p_r[0][15:0]}) - (cmd.corner[2] ? $signed(ONE_W) : 17'sd0);
  assign oy = $signed({1'b0, p_r[1][15:0]}) - (cmd.corner[1] ? $signed(ONE_W) : 17'sd0);
  assign oz = $signed({1'b0, p_r[2][15:0]}) - (cmd.corner[0] ? $signed(ONE_W) : 17'sd0);
  assign wx = cmd.corner[2] ? fade_r[0] : ONE_W - fade_r[0];
  assign wy = cmd.corner[1] ? fade_r[1] : ONE_W - fade_r[1];
  assign wz = cmd.corner[0] ? fade_r[2] : ONE_W - fade_r[2];
  assign ax = p_r[0][23:16] + {7'd0, cmd.corner[2]};
  assign ay = p_r[1][23:16] + {7'd0, cmd.corner[1]};
  assign az = p_r[2][23:16] + {7'd0, cmd.corner[0]};
  assign gidx   = pxq_r ^ pyq_r ^ pzq_r;
  assign dot_sh = dot_r[34:15];

  // one shared multiplier, operands picked by the current step
  always_comb begin
    mul_a = 24'sd0;
    mul_b = 20'sd0;
    case (cmd.op)
      DP_FADE_SQ: begin
        mul_a = $signed({8'd0, f_sel});
        mul_b = $signed({4'd0, f_sel});
      end
      DP_FADE_MUL: begin
        mul_a = $signed({8'd0, tmp_r});
        mul_b = $signed({2'd0, FADE_K - {1'b0, f_sel, 1'b0}});
      end
      DP_DOT_X: begin
        mul_a = $signed({{8{gq_r[15]}}, gq_r[15:0]});
        mul_b = $signed({{3{ox[16]}}, ox});
      end
      DP_DOT_Y: begin
        mul_a = $signed({{8{gq_r[31]}}, gq_r[31:16]});
        mul_b = $signed({{3{oy[16]}}, oy});
      end
      DP_DOT_Z: begin
        mul_a = $signed({{8{gq_r[47]}}, gq_r[47:32]});
        mul_b = $signed({{3{oz[16]}}, oz});
      end
      DP_W_X: begin
        mul_a = $signed({{4{dot_sh[19]}}, dot_sh});
        mul_b = $signed({3'd0, wx});
      end
      DP_W_Y: begin
        mul_a = d_r;
        mul_b = $signed({3'd0, wy});
      end
      DP_W_Z: begin
        mul_a = d_r;
        mul_b = $signed({3'd0, wz});
      end
      default: begin
        mul_a = 24'sd0;
        mul_b = 20'sd0;
      end
    endcase
  end

  assign mul_p      = mul_a * mul_b;
  assign prod_sh    = mul_p[39:16];
  assign acc_ext    = {{10{acc_r[23]}}, acc_r};
  assign acc_scaled = acc_ext <<< (3'd7 - cmd.octave);

  // absolute value for turbulence, floor to 16 fraction bits, saturate
  always_comb begin
    mag = (turb_r && total_r[33]) ? -total_r : total_r;
    res = mag[33:7];
    if (res > 27'sd524287) begin
      sat = 20'sh7FFFF;
    end else if (res < -27'sd524288) begin
      sat = 20'sh80000;
    end else begin
      sat = res[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      if (in_op == OP_LOAD_PX) perm_x_mem[entry_index] <= perm_value;
      if (in_op == OP_LOAD_PY) perm_y_mem[entry_index] <= perm_value;
      if (in_op == OP_LOAD_PZ) perm_z_mem[entry_index] <= perm_value;
      if (in_op == OP_LOAD_G)  grad_mem[entry_index] <= {grad_z, grad_y, grad_x};
    end
    if (cmd.op == DP_PERM_RD) begin
      pxq_r <= perm_x_mem[ax];
      pyq_r <= perm_y_mem[ay];
      pzq_r <= perm_z_mem[az];
    end
    if (cmd.op == DP_GRAD_RD) begin
      gq_r <= grad_mem[gidx];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_START: begin
        p_r[0]  <= point_x[23:0];
        p_r[1]  <= point_y[23:0];
        p_r[2]  <= point_z[23:0];
        total_r <= 34'sd0;
        acc_r   <= 24'sd0;
        turb_r  <= (in_op == OP_TURB);
      end
      DP_FADE_SQ:  tmp_r <= mul_p[31:16];
      DP_FADE_MUL: fade_r[cmd.axis] <= mul_p[32:16];
      DP_DOT_X:    dot_r <= mul_p[34:0];
      DP_DOT_Y:    dot_r <= dot_r + mul_p[34:0];
      DP_DOT_Z:    dot_r <= dot_r + mul_p[34:0];
      DP_W_X:      d_r <= prod_sh;
      DP_W_Y:      d_r <= prod_sh;
      DP_W_Z:      acc_r <= acc_r + prod_sh;
      DP_OCT_END: begin
        total_r <= total_r + acc_scaled;
        acc_r   <= 24'sd0;
        // double the point for the next octave
        p_r[0]  <= {p_r[0][22:0], 1'b0};
        p_r[1]  <= {p_r[1][22:0], 1'b0};
        p_r[2]  <= {p_r[2][22:0], 1'b0};
      end
      DP_FINISH:   noise_r <= sat;
      default: begin
      end
    endcase
  end

  assign noise_value = noise_r;

endmodule
`default_nettype wire

### rtl/perlin_gradient_noise_turbulence.sv
// ----------------------------------------------------------------------------
// perlin_gradient_noise_turbulence
// 3D fixed-point gradient noise with octave turbulence.
// ----------------------------------------------------------------------------
// Load words (operations 0..3) write one table entry. A noise word runs one
// octave, a turbulence word N octaves, capped at 8 (N = 0 gives zero): each
// octave works out the fade weight of each axis, then for each of the eight
// corners reads the tables, forms the dot product and weights it, then folds
// the octave into the total, all through one shared 24x20 multiplier and the single
// read port of each table. One evaluation is in flight at a time; the result
// waits in an output register.
`default_nettype none
module perlin_gradient_noise_turbulence (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [7:0] entry_index, [15:8] perm_value, [31:16] grad_x, [47:32] grad_y,
  // [63:48] grad_z, [95:64] point_x, [127:96] point_y, [159:128] point_z,
  // [163:160] octaves, [167:164] zero
  input  wire logic [167:0] in_tdata,
  // [2:0] operation
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [19:0] noise_value, [23:20] zero
  output logic [23:0]       out_tdata
);
  import pgn_pkg::*;

  pgn_cmd_t           cmd;
  logic signed [19:0] noise_value;

  pgn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .in_octaves (in_tdata[163:160]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  pgn_dpath u_dpath (
    .clk         (clk),
    .cmd         (cmd),
    .in_op       (in_tuser),
    .entry_index (in_tdata[7:0]),
    .perm_value  (in_tdata[15:8]),
    .grad_x      (in_tdata[31:16]),
    .grad_y      (in_tdata[47:32]),
    .grad_z      (in_tdata[63:48]),
    .point_x     (in_tdata[95:64]),
    .point_y     (in_tdata[127:96]),
    .point_z     (in_tdata[159:128]),
    .noise_value (noise_value)
  );

  assign out_tdata = {4'd0, noise_value};

`include "perlin_gradient_noise_turbulence_macros.svh"

  `PGN_ASSERT(a_eval_busy, in_tvalid && in_tready && (in_tuser == OP_NOISE || in_tuser == OP_TURB) |=> !in_tready)
  `PGN_ASSERT(a_load_ready, in_tvalid && in_tready && (in_tuser == OP_LOAD_PX || in_tuser == OP_LOAD_G) |=> in_tready)
  `PGN_ASSERT(a_valid_src, $rose(out_tvalid) |-> $past(cmd.op == DP_FINISH))
  `PGN_NEVER(a_no_clobber, cmd.op == DP_FINISH && out_tvalid && !out_tready)

endmodule
`default_nettype wire

### verif/tb_perlin_gradient_noise_turbulence.sv
// ----------------------------------------------------------------------------
// tb_perlin_gradient_noise_turbulence
// Fills the permutation and gradient tables, then runs directed and random
// noise and turbulence words against an in-bench fixed-point predictor,
// with bursty input traffic and a stalling result receiver.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_perlin_gradient_noise_turbulence;
  import pgn_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_CYCLES = 700;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;

  perlin_gradient_noise_turbulence dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // predictor copy of the tables
  logic [7:0] perm_x [256];
  logic [7:0] perm_y [256];
  logic [7:0] perm_z [256];
  shortint    grad_tab [256][3];

  logic signed [19:0] noise_expected [$];
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_perlin_gradient_noise_turbulence NOT OK");
      $finish;
    end
  end

  // receiver: switch between always-ready, random stalls and long stalls
  int stall_mode = 0;
  int stall_count = 0;
  always @(posedge clk) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(2, 0);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(9, 0) > 2);
      default: begin
        if (stall_count > 0) begin
          stall_count <= stall_count - 1;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(7, 0) == 0) stall_count <= $urandom_range(25, 1);
        end
      end
    endcase
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    logic signed [19:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (noise_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", out_tdata));
      end else begin
        want = noise_expected.pop_front();
        if (out_tdata[19:0] !== want)
          report_mismatch($sformatf("noise_value got %0d want %0d",
                                    $signed(out_tdata[19:0]), want));
        if (out_tdata[23:20] !== 4'd0)
          report_mismatch($sformatf("pad bits %h", out_tdata[23:20]));
      end
    end
  end

  function automatic longint fade_weight(input longint f);
    longint sq;
    sq = (f * f) >>> 16;
    return (sq * (3 * 65536 - 2 * f)) >>> 16;
  endfunction

  function automatic longint octave_sum(input longint px, input longint py,
                                        input longint pz);
    longint fr[3], fd[3], pt[3], acc, d, ox, oy, oz, wx, wy, wz;
    int base[3], idx;
    acc = 0;
    pt[0] = px; pt[1] = py; pt[2] = pz;
    for (int k = 0; k < 3; k++) begin
      fr[k] = pt[k] & 64'hFFFF;
      base[k] = int'((pt[k] >> 16) & 64'hFF);
      fd[k] = fade_weight(fr[k]);
    end
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        for (int c = 0; c < 2; c++) begin
          idx = int'(perm_x[(base[0] + a) & 255] ^ perm_y[(base[1] + b) & 255]
                     ^ perm_z[(base[2] + c) & 255]);
          ox = fr[0] - (a ? 65536 : 0);
          oy = fr[1] - (b ? 65536 : 0);
          oz = fr[2] - (c ? 65536 : 0);
          d = longint'(grad_tab[idx][0]) * ox + longint'(grad_tab[idx][1]) * oy
              + longint'(grad_tab[idx][2]) * oz;
          wx = a ? fd[0] : 65536 - fd[0];
          wy = b ? fd[1] : 65536 - fd[1];
          wz = c ? fd[2] : 65536 - fd[2];
          d = d >>> 15;
          d = (d * wx) >>> 16;
          d = (d * wy) >>> 16;
          d = (d * wz) >>> 16;
          acc += d;
        end
    return acc;
  endfunction

  // apply one word to the table copy; push the expected noise value if any
  task automatic predict_word(input logic [2:0] op, input logic [167:0] w);
    longint p0[3], total, r;
    int n;
    case (op)
      OP_LOAD_PX: perm_x[w[7:0]] = w[15:8];
      OP_LOAD_PY: perm_y[w[7:0]] = w[15:8];
      OP_LOAD_PZ: perm_z[w[7:0]] = w[15:8];
      OP_LOAD_G: begin
        grad_tab[w[7:0]][0] = w[31:16];
        grad_tab[w[7:0]][1] = w[47:32];
        grad_tab[w[7:0]][2] = w[63:48];
      end
      OP_NOISE, OP_TURB: begin
        p0[0] = longint'($signed(w[95:64]));
        p0[1] = longint'($signed(w[127:96]));
        p0[2] = longint'($signed(w[159:128]));
        n = (op == OP_NOISE) ? 1 :
            ((int'(w[163:160]) > MAXOCT) ? MAXOCT : int'(w[163:160]));
        total = 0;
        for (int o = 0; o < n; o++)
          total += octave_sum(p0[0] << o, p0[1] << o, p0[2] << o)
                   * (64'sd1 <<< (MAXOCT - 1 - o));
        if (op == OP_TURB && total < 0) total = -total;
        r = total >>> (FRAC + MAXOCT - 1 - 16);
        if (r > 524287) r = 524287;
        if (r < -524288) r = -524288;
        noise_expected.push_back(r[19:0]);
      end
      default: ;
    endcase
  endtask

  // drive one word, hold until accepted, then maybe open a gap when a burst ends
  task automatic send_word(input logic [2:0] op, input logic [167:0] w);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(op, w);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12, 0);
      if ($urandom_range(3, 0) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk);
      end
    end
  endtask

  function automatic logic [167:0] pack_word(input logic [7:0] ent,
      input logic [7:0] pv, input logic [15:0] gx, input logic [15:0] gy,
      input logic [15:0] gz, input logic [31:0] px, input logic [31:0] py,
      input logic [31:0] pz, input logic [3:0] oct);
    return {4'd0, oct, pz, py, px, gz, gy, gx, pv, ent};
  endfunction

  task automatic send_eval(input logic [2:0] op, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] pz,
                           input logic [3:0] oct);
    send_word(op, pack_word(8'($urandom), 8'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), px, py, pz, oct));
  endtask

  task automatic send_load(input logic [2:0] op, input logic [7:0] ent);
    send_word(op, pack_word(ent, 8'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), $urandom, $urandom, $urandom,
                            4'($urandom)));
  endtask

  // every entry is written before any evaluation reads it
  task automatic test_table_fill();
    for (int i = 0; i < 256; i++) begin
      send_load(OP_LOAD_PX, 8'(i));
      send_load(OP_LOAD_PY, 8'(i));
      send_load(OP_LOAD_PZ, 8'(i));
      send_load(OP_LOAD_G, 8'(i));
    end
    // extreme gradients and permutation values
    send_word(OP_LOAD_G, pack_word(8'd0, 8'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                   '0, '0, '0, '0));
    send_word(OP_LOAD_G, pack_word(8'd255, 8'd0, 16'h8000, 16'h8000, 16'h8000,
                                   '0, '0, '0, '0));
    send_word(OP_LOAD_PX, pack_word(8'd0, 8'd255, '0, '0, '0, '0, '0, '0, '0));
    send_word(OP_LOAD_PY, pack_word(8'd255, 8'd0, '0, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_directed();
    send_eval(OP_NOISE, 32'd0, 32'd0, 32'd0, 4'd0);
    send_eval(OP_NOISE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd15);
    send_eval(OP_NOISE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 4'd3);
    send_eval(OP_NOISE, 32'h0000_FFFF, 32'h0000_8000, 32'h0001_0001, 4'd0);
    send_eval(OP_NOISE, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h00FF_FFFF, 4'd8);
    send_eval(OP_TURB, 32'h0001_8000, 32'h0002_4000, 32'h0003_C000, 4'd0);
    send_eval(OP_TURB, 32'h0001_8000, 32'h0002_4000, 32'h0003_C000, 4'd1);
    send_eval(OP_TURB, 32'h0001_8000, 32'h0002_4000, 32'h0003_C000, 4'd8);
    send_eval(OP_TURB, 32'h0001_8000, 32'h0002_4000, 32'h0003_C000, 4'd9);
    send_eval(OP_TURB, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 4'd15);
    send_eval(OP_TURB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 4'd7);
    send_eval(OP_TURB, 32'hFFFF_8000, 32'hFFFE_2000, 32'hFFFD_F000, 4'd4);
    send_eval(OP_SPARE_A, $urandom, $urandom, $urandom, 4'($urandom));
    send_eval(OP_SPARE_B, $urandom, $urandom, $urandom, 4'($urandom));
    send_eval(OP_NOISE, 32'h00FF_FFFF, 32'h0000_0001, 32'h00FF_0000, 4'd2);
  endtask

  function automatic logic [31:0] rand_coord();
    // mostly near the origin, sometimes anywhere
    if ($urandom_range(3, 0) == 0) return $urandom;
    return $urandom_range(32'h0040_0000, 0) - 32'h0020_0000;
  endfunction

  task automatic test_random(input int count);
    int kind;
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      // hold off until every pending result is back
      if (i == count / 2) begin
        in_tvalid <= 1'b0;
        wait (noise_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      kind = $urandom_range(99, 0);
      if (kind < 30) begin
        send_eval(OP_NOISE, rand_coord(), rand_coord(), rand_coord(),
                  4'($urandom));
      end else if (kind < 65) begin
        // low octave counts keep the run short
        send_eval(OP_TURB, rand_coord(), rand_coord(), rand_coord(),
                  ($urandom_range(4, 0) == 0) ? 4'($urandom_range(15, 0))
                                              : 4'($urandom_range(3, 0)));
      end else if (kind < 93) begin
        op = 3'($urandom_range(3, 0));
        send_load(op, 8'($urandom));
      end else begin
        send_eval(($urandom_range(1, 0) != 0) ? OP_SPARE_A : OP_SPARE_B,
                  $urandom, $urandom, $urandom, 4'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_directed();
    test_random(850);
    in_tvalid <= 1'b0;
    wait (noise_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && noise_expected.size() == 0) begin
      $display("tb_perlin_gradient_noise_turbulence OK");
    end else begin
      $display("tb_perlin_gradient_noise_turbulence NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
